[rtl/core/rflp_pkg.sv]
// ----------------------------------------------------------------------------
// Record field layout packer package
// Shared types, type codes and helper functions for the layout packer.
// ----------------------------------------------------------------------------
package rflp_pkg;

   localparam int OFS_W      = 21;
   localparam int EMIT_LIMIT = 32;

   // Field type codes.
   localparam logic [2:0] FT_BOOL  = 3'd0;
   localparam logic [2:0] FT_BYTE  = 3'd1;
   localparam logic [2:0] FT_I32   = 3'd2;
   localparam logic [2:0] FT_I64   = 3'd3;
   localparam logic [2:0] FT_F64   = 3'd4;
   localparam logic [2:0] FT_VAR32 = 3'd5;
   localparam logic [2:0] FT_FIXED = 3'd6;

   // Configuration register indexes.
   localparam logic [0:0] CSR_FIELD_ORDER = 1'd0;
   localparam logic [0:0] CSR_PAD_MODE    = 1'd1;

   localparam logic [2:0] LAST_PASS = 3'd4;

   typedef enum logic [2:0] {
      CL_BITS,
      CL_BYTES,
      CL_INT32,
      CL_VAR32,
      CL_EIGHT
   } fclass_type;

   typedef struct packed {
      logic [2:0]  field_type;
      logic [15:0] fixed_size;
      logic        nullable;
      logic        last_field;
   } req_type;

   typedef struct packed {
      logic [4:0]       entry_index;
      logic             is_null_marker;
      logic [OFS_W-1:0] byte_offset;
      logic [2:0]       bit_position;
      logic [15:0]      entry_size;
      logic [OFS_W-1:0] record_size;
      logic [OFS_W-1:0] bool_byte_count;
      logic             overflow;
      logic             last_result;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  ftype;
      logic [15:0] size;
      logic        null_mark;
   } ent_type;

   typedef struct packed {
      logic [OFS_W-1:0] offset;
      logic [2:0]       bitpos;
   } place_type;

   typedef struct packed {
      logic       load_field;
      logic       load_null;
      logic       start_run;
      logic       scan_rd;
      logic       pass_end;
      logic       emit_rd;
      logic       out_load;
      logic       run_clear;
      logic [2:0] pass_idx;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic emit_last;
   } sts_type;

   function automatic fclass_type class_of(input logic [2:0] t);
      fclass_type c;
      case (t)
         FT_BOOL: c = CL_BITS;
         FT_I32: c = CL_INT32;
         FT_I64, FT_F64: c = CL_EIGHT;
         FT_VAR32: c = CL_VAR32;
         default: c = CL_BYTES;
      endcase
      return c;
   endfunction

   function automatic logic [15:0] size_of(input logic [2:0] t, input logic [15:0] fixed);
      logic [15:0] s;
      case (t)
         FT_I32, FT_VAR32: s = 16'd4;
         FT_I64, FT_F64: s = 16'd8;
         FT_FIXED: s = (fixed == 16'd0) ? 16'd1 : fixed;
         default: s = 16'd1;
      endcase
      return s;
   endfunction

   // Class placed in each of the five passes for the given packing order.
   function automatic fclass_type pass_class(input logic mode, input logic [2:0] pass);
      fclass_type c;
      if (!mode) begin
         case (pass)
            3'd0: c = CL_BITS;
            3'd1: c = CL_BYTES;
            3'd2: c = CL_INT32;
            3'd3: c = CL_VAR32;
            default: c = CL_EIGHT;
         endcase
      end else begin
         case (pass)
            3'd0: c = CL_EIGHT;
            3'd1: c = CL_INT32;
            3'd2: c = CL_VAR32;
            3'd3: c = CL_BYTES;
            default: c = CL_BITS;
         endcase
      end
      return c;
   endfunction

endpackage

[rtl/core/rflp_ctrl.sv]
// ----------------------------------------------------------------------------
// Layout packer controller
// Sequences field loading, the five placement passes and result emission.
// ----------------------------------------------------------------------------
module rflp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_nullable,
   input  logic              req_last,
   output logic              req_ready,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   input  rflp_pkg::sts_type sts,
   output rflp_pkg::cmd_type cmd
);
   import rflp_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_NULL,
      S_PREP,
      S_SCAN,
      S_DRAIN,
      S_PEND,
      S_EMIT_RD,
      S_EMIT_WT
   } state_type;

   state_type  state_ff, state_in;
   logic       last_pend_ff, last_pend_in;
   logic [2:0] pass_ff, pass_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      last_pend_in = last_pend_ff;
      pass_in      = pass_ff;
      cmd          = '0;
      cmd.pass_idx = pass_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_field = 1'b1;
               last_pend_in   = req_last;
               if (req_nullable) begin
                  state_in = S_NULL;
               end else if (req_last) begin
                  state_in = S_PREP;
               end
            end
         end
         S_NULL: begin
            cmd.load_null = 1'b1;
            state_in = last_pend_ff ? S_PREP : S_IDLE;
         end
         S_PREP: begin
            cmd.start_run = 1'b1;
            pass_in  = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (sts.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // The last entry read in the scan is placed in this cycle.
            state_in = S_PEND;
         end
         S_PEND: begin
            cmd.pass_end = 1'b1;
            if (pass_ff == LAST_PASS) begin
               state_in = S_EMIT_RD;
            end else begin
               pass_in  = pass_ff + 3'd1;
               state_in = S_SCAN;
            end
         end
         S_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in = S_EMIT_WT;
         end
         S_EMIT_WT: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               if (sts.emit_last) begin
                  cmd.run_clear = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_pend_ff <= 1'b0;
         pass_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_pend_ff <= last_pend_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/core/rflp_dp.sv]
// ----------------------------------------------------------------------------
// Layout packer datapath
// Entry stores, class counters, placement arithmetic and the result register.
// ----------------------------------------------------------------------------
module rflp_dp #(
   parameter int MAX_ENTRIES = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  rflp_pkg::cmd_type cmd,
   input  rflp_pkg::req_type req_payload,
   input  logic              field_order_mode,
   input  logic              pad_mode,
   output rflp_pkg::sts_type sts,
   output rflp_pkg::rsp_type rsp_payload
);
   import rflp_pkg::*;

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   ent_type   ent_mem [MAX_ENTRIES];
   place_type off_mem [MAX_ENTRIES];

   logic [CW-1:0]    count_ff, count_in;
   logic [5:0]       cnt_i32_ff, cnt_i32_in;
   logic [5:0]       cnt_v32_ff, cnt_v32_in;
   logic [5:0]       cnt_e8_ff, cnt_e8_in;
   logic             ovf_ff, ovf_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic             rd_valid_ff;
   logic [AW-1:0]    rd_addr_ff;
   ent_type          ent_q_ff;
   place_type        off_q_ff;
   logic [OFS_W-1:0] running_ff, running_in;
   logic [2:0]       bit_ff, bit_in;
   logic [OFS_W-1:0] bb_ff, bb_in;
   logic             has4_ff, has4_in;
   logic             has8_ff, has8_in;
   rsp_type          out_ff;

   logic             store_req;
   logic             room;
   ent_type          new_ent;
   fclass_type       new_cls;
   logic             proc_hit;
   logic [OFS_W-1:0] rnd_ofs;
   logic [OFS_W-1:0] bool_end;
   logic [6:0]       cnt7;
   logic [6:0]       emit_n;

   assign store_req = cmd.load_field || cmd.load_null;
   assign room      = 7'(count_ff) < 7'(MAX_ENTRIES);

   always_comb begin
      if (cmd.load_null) begin
         new_ent = '{ftype: FT_BOOL, size: 16'd1, null_mark: 1'b1};
      end else begin
         new_ent = '{ftype: req_payload.field_type,
                     size: size_of(req_payload.field_type, req_payload.fixed_size),
                     null_mark: 1'b0};
      end
   end
   assign new_cls = class_of(new_ent.ftype);

   // Loading: entry count, saturating class counters and the overflow flag.
   always_comb begin
      count_in   = count_ff;
      cnt_i32_in = cnt_i32_ff;
      cnt_v32_in = cnt_v32_ff;
      cnt_e8_in  = cnt_e8_ff;
      ovf_in     = ovf_ff;
      if (cmd.run_clear) begin
         count_in   = '0;
         cnt_i32_in = '0;
         cnt_v32_in = '0;
         cnt_e8_in  = '0;
         ovf_in     = 1'b0;
      end else if (store_req) begin
         if (!room) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CW'(1);
            if (new_cls == CL_INT32 && cnt_i32_ff != 6'd63) begin
               cnt_i32_in = cnt_i32_ff + 6'd1;
            end
            if (new_cls == CL_VAR32 && cnt_v32_ff != 6'd63) begin
               cnt_v32_in = cnt_v32_ff + 6'd1;
            end
            if (new_cls == CL_EIGHT && cnt_e8_ff != 6'd63) begin
               cnt_e8_in = cnt_e8_ff + 6'd1;
            end
         end
      end
   end

   always_comb begin
      addr_in = addr_ff;
      if (cmd.start_run || cmd.pass_end) begin
         addr_in = '0;
      end else if (cmd.scan_rd || cmd.out_load) begin
         addr_in = addr_ff + AW'(1);
      end
   end

   assign proc_hit = rd_valid_ff &&
                     (class_of(ent_q_ff.ftype) == pass_class(field_order_mode, cmd.pass_idx));
   assign rnd_ofs  = (bit_ff != 3'd0) ? running_ff + OFS_W'(1) : running_ff;
   assign bool_end = running_ff + OFS_W'(1);

   // Placement: one entry per cycle, then end-of-pass byte rounding and padding.
   always_comb begin
      running_in = running_ff;
      bit_in     = bit_ff;
      bb_in      = bb_ff;
      has4_in    = has4_ff;
      has8_in    = has8_ff;
      if (cmd.start_run) begin
         running_in = '0;
         bit_in     = '0;
         bb_in      = '0;
         has4_in    = (cnt_i32_ff != 6'd0) || (cnt_v32_ff != 6'd0);
         has8_in    = (cnt_e8_ff != 6'd0);
      end else if (proc_hit) begin
         if (class_of(ent_q_ff.ftype) == CL_BITS) begin
            bit_in = bit_ff + 3'd1;
            if (bit_ff == 3'd7) begin
               running_in = running_ff + OFS_W'(1);
            end
            if (bool_end > bb_ff) begin
               bb_in = bool_end;
            end
         end else begin
            running_in = running_ff + OFS_W'(ent_q_ff.size);
         end
      end else if (cmd.pass_end) begin
         bit_in     = '0;
         running_in = rnd_ofs;
         if (!field_order_mode) begin
            if (cmd.pass_idx == 3'd1 && (!pad_mode || has4_ff)) begin
               running_in = (rnd_ofs + OFS_W'(3)) & ~OFS_W'(3);
            end else if (cmd.pass_idx == 3'd3 && (!pad_mode || has8_ff)) begin
               running_in = (rnd_ofs + OFS_W'(7)) & ~OFS_W'(7);
            end
         end else if (cmd.pass_idx == LAST_PASS) begin
            if (has8_ff || !pad_mode) begin
               running_in = (rnd_ofs + OFS_W'(7)) & ~OFS_W'(7);
            end else if (has4_ff) begin
               running_in = (rnd_ofs + OFS_W'(3)) & ~OFS_W'(3);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         cnt_i32_ff  <= '0;
         cnt_v32_ff  <= '0;
         cnt_e8_ff   <= '0;
         ovf_ff      <= 1'b0;
         addr_ff     <= '0;
         rd_valid_ff <= 1'b0;
         running_ff  <= '0;
         bit_ff      <= '0;
         bb_ff       <= '0;
         has4_ff     <= 1'b0;
         has8_ff     <= 1'b0;
      end else begin
         count_ff    <= count_in;
         cnt_i32_ff  <= cnt_i32_in;
         cnt_v32_ff  <= cnt_v32_in;
         cnt_e8_ff   <= cnt_e8_in;
         ovf_ff      <= ovf_in;
         addr_ff     <= addr_in;
         rd_valid_ff <= cmd.scan_rd;
         running_ff  <= running_in;
         bit_ff      <= bit_in;
         bb_ff       <= bb_in;
         has4_ff     <= has4_in;
         has8_ff     <= has8_in;
      end
   end

   // Entry stores.
   always_ff @(posedge clock) begin
      if (store_req && room) begin
         ent_mem[count_ff[AW-1:0]] <= new_ent;
      end
      if (cmd.scan_rd || cmd.emit_rd) begin
         ent_q_ff <= ent_mem[addr_ff];
      end
      if (cmd.scan_rd) begin
         rd_addr_ff <= addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_hit) begin
         off_mem[rd_addr_ff] <= '{offset: running_ff, bitpos: bit_ff};
      end
      if (cmd.emit_rd) begin
         off_q_ff <= off_mem[addr_ff];
      end
   end

   assign cnt7          = 7'(count_ff);
   assign emit_n        = (cnt7 > 7'(EMIT_LIMIT)) ? 7'(EMIT_LIMIT) : cnt7;
   assign sts.scan_last = (7'(addr_ff) + 7'd1) == cnt7;
   assign sts.emit_last = (7'(addr_ff) + 7'd1) == emit_n;

   // Result register; it holds its value while a transfer is stalled.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff.entry_index     <= 5'(addr_ff);
         out_ff.is_null_marker  <= ent_q_ff.null_mark;
         out_ff.byte_offset     <= off_q_ff.offset;
         out_ff.bit_position    <= (ent_q_ff.ftype == FT_BOOL) ? off_q_ff.bitpos : 3'd0;
         out_ff.entry_size      <= ent_q_ff.size;
         out_ff.record_size     <= running_ff;
         out_ff.bool_byte_count <= bb_ff;
         out_ff.overflow        <= ovf_ff;
         out_ff.last_result     <= sts.emit_last;
      end
   end

   assign rsp_payload = out_ff;

endmodule

[rtl/core/record_field_layout_packer.sv]
// A field is taken when idle; a nullable one also stores a hidden null entry.
// After the last field the five placement passes scan the stored entries,
// one entry read per cycle from the entry store.
// Results then follow one at a time, each a store read and a load.
// A new schema is taken once the final result sits in the result register.
// Synchronous reset clears control state and both registers; stores need none.
// ----------------------------------------------------------------------------
// Record field layout packer
// Collects a record schema field by field, places every entry by type class
// and reports the byte offset and bool bit of each entry.
// ----------------------------------------------------------------------------
module record_field_layout_packer #(
   parameter int MAX_ENTRIES = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rflp_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rflp_pkg::rsp_type rsp_payload,
   input  logic              csr_we,
   input  logic [0:0]        csr_index,
   input  logic [0:0]        csr_data
);
   import rflp_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    order_ff;
   logic    pad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= 1'b0;
         pad_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIELD_ORDER: order_ff <= csr_data[0];
            CSR_PAD_MODE: pad_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   rflp_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_nullable (req_payload.nullable),
      .req_last     (req_payload.last_field),
      .req_ready    (req_ready),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .sts          (sts),
      .cmd          (cmd)
   );

   rflp_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_payload      (req_payload),
      .field_order_mode (order_ff),
      .pad_mode         (pad_ff),
      .sts              (sts),
      .rsp_payload      (rsp_payload)
   );

endmodule

[rtl/core/rflp_checker.sv]
// ----------------------------------------------------------------------------
// Layout packer port checker
// Checks port behavior of the layout packer over time.
// ----------------------------------------------------------------------------
module rflp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input rflp_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rflp_pkg::rsp_type rsp_payload
);
   import rflp_pkg::*;

   // A result that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   // The final field of a schema starts a run, so no field is taken next.
   a_run_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.last_field |=> !req_ready)
      else $error("field taken right after the last field");

   // A hidden null entry is one byte and always follows its field.
   a_null_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.is_null_marker |->
         rsp_payload.entry_size == 16'd1 && rsp_payload.entry_index != 5'd0)
      else $error("malformed null entry");

   // Reset leaves no result pending and the input open.
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

endmodule

bind record_field_layout_packer rflp_checker u_rflp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

[tb/record_field_layout_packer_tb.sv]
// ----------------------------------------------------------------------------
// Record field layout packer testbench
// Feeds record schemas field by field under every packing and padding mode,
// predicts the placement of every stored entry and checks each result
// transfer against the predicted layout, with random stalls on both sides.
// ----------------------------------------------------------------------------
module record_field_layout_packer_tb;
   import rflp_pkg::*;

   localparam int         MAX_ENT     = 32;
   localparam int         CYCLE_LIMIT = 600000;
   localparam int         DRAIN_GAP   = 16;
   localparam int         HOLD_CYCLES = 400;
   localparam logic [2:0] FT_UNKNOWN  = 3'd7;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_payload = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_payload;
   logic       csr_we = 1'b0;
   logic [0:0] csr_index = CSR_FIELD_ORDER;
   logic [0:0] csr_data = 1'b0;

   record_field_layout_packer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #4 clock = ~clock;

   // Predicted copy of the block's schema store and placement state.
   logic [2:0]  ent_ftype [MAX_ENT];
   logic [15:0] ent_size  [MAX_ENT];
   logic        ent_null  [MAX_ENT];
   logic [20:0] ent_ofs   [MAX_ENT];
   logic [2:0]  ent_bit   [MAX_ENT];
   int          ent_count = 0;
   int          n_int32 = 0;
   int          n_var32 = 0;
   int          n_eight = 0;
   logic [20:0] run_ofs = '0;
   logic        ovf_flag = 1'b0;
   logic        cfg_order = 1'b0;
   logic        cfg_pad = 1'b0;

   req_type     field_q [$];
   rsp_type     layout_q [$];
   int          errors = 0;
   int          cycle_count = 0;
   int          hold_left = 0;
   logic        hold_done = 1'b0;
   logic        hold_request = 1'b0;
   logic        no_idle = 1'b0;

   function automatic fclass_type field_class(logic [2:0] t);
      case (t)
         FT_BOOL: return CL_BITS;
         FT_I32: return CL_INT32;
         FT_I64, FT_F64: return CL_EIGHT;
         FT_VAR32: return CL_VAR32;
         default: return CL_BYTES;
      endcase
   endfunction

   function automatic logic [15:0] field_bytes(logic [2:0] t, logic [15:0] fixed);
      if (t == FT_I32 || t == FT_VAR32) return 16'd4;
      if (t == FT_I64 || t == FT_F64) return 16'd8;
      if (t == FT_FIXED && fixed != 16'd0) return fixed;
      return 16'd1;
   endfunction

   function automatic void add_entry(logic [2:0] t, logic [15:0] sz, logic nm);
      fclass_type c;
      if (ent_count >= MAX_ENT) begin
         ovf_flag = 1'b1;
         return;
      end
      ent_ftype[ent_count] = t;
      ent_size[ent_count]  = sz;
      ent_null[ent_count]  = nm;
      ent_count++;
      c = field_class(t);
      if (c == CL_INT32 && n_int32 < 63) n_int32++;
      if (c == CL_VAR32 && n_var32 < 63) n_var32++;
      if (c == CL_EIGHT && n_eight < 63) n_eight++;
   endfunction

   function automatic void place_class(fclass_type cls);
      int bitn;
      bitn = 0;
      for (int i = 0; i < ent_count; i++) begin
         if (field_class(ent_ftype[i]) != cls) continue;
         ent_ofs[i] = run_ofs;
         if (cls == CL_BITS) begin
            ent_bit[i] = 3'(bitn);
            bitn++;
            if (bitn == 8) begin
               run_ofs = run_ofs + 21'd1;
               bitn = 0;
            end
         end else begin
            ent_bit[i] = 3'd0;
            run_ofs = run_ofs + 21'(ent_size[i]);
         end
      end
      // A partly filled bool byte still takes a whole byte.
      if (bitn > 0) run_ofs = run_ofs + 21'd1;
   endfunction

   function automatic void pad_to(logic [20:0] align);
      run_ofs = (run_ofs + (align - 21'd1)) & ~(align - 21'd1);
   endfunction

   function automatic void predict_layout(req_type f);
      logic        has4;
      logic        has8;
      logic [20:0] bool_span;
      logic [20:0] b;
      int          n;
      rsp_type     r;
      add_entry(f.field_type, field_bytes(f.field_type, f.fixed_size), 1'b0);
      if (f.nullable) add_entry(FT_BOOL, 16'd1, 1'b1);
      if (!f.last_field) return;
      has4 = (n_int32 > 0) || (n_var32 > 0);
      has8 = n_eight > 0;
      run_ofs = '0;
      if (!cfg_order) begin
         place_class(CL_BITS);
         place_class(CL_BYTES);
         if (!cfg_pad || has4) pad_to(21'd4);
         place_class(CL_INT32);
         place_class(CL_VAR32);
         if (!cfg_pad || has8) pad_to(21'd8);
         place_class(CL_EIGHT);
      end else begin
         place_class(CL_EIGHT);
         place_class(CL_INT32);
         place_class(CL_VAR32);
         place_class(CL_BYTES);
         place_class(CL_BITS);
         if (has8 || !cfg_pad) pad_to(21'd8);
         else if (has4) pad_to(21'd4);
      end
      bool_span = '0;
      for (int i = 0; i < ent_count; i++) begin
         if (ent_ftype[i] == FT_BOOL) begin
            b = ent_ofs[i] + 21'd1;
            if (b > bool_span) bool_span = b;
         end
      end
      n = (ent_count < EMIT_LIMIT) ? ent_count : EMIT_LIMIT;
      for (int i = 0; i < n; i++) begin
         r.entry_index     = 5'(i);
         r.is_null_marker  = ent_null[i];
         r.byte_offset     = ent_ofs[i];
         r.bit_position    = (ent_ftype[i] == FT_BOOL) ? ent_bit[i] : 3'd0;
         r.entry_size      = ent_size[i];
         r.record_size     = run_ofs;
         r.bool_byte_count = bool_span;
         r.overflow        = ovf_flag;
         r.last_result     = (i == n - 1);
         layout_q.insert(layout_q.size(), r);
      end
      ent_count = 0;
      n_int32   = 0;
      n_var32   = 0;
      n_eight   = 0;
      run_ofs   = '0;
      ovf_flag  = 1'b0;
   endfunction

   task automatic report_error(string msg);
      if (errors < 100) $display("ERROR cycle %0d: %s", cycle_count, msg);
      errors++;
   endtask

   task automatic cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_error($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   task automatic check_result(rsp_type got);
      rsp_type want;
      if (layout_q.size() == 0) begin
         report_error($sformatf("result transfer for entry %0d with nothing expected",
                                got.entry_index));
         return;
      end
      want = layout_q.pop_front();
      cmp_field("entry_index", 32'(got.entry_index), 32'(want.entry_index));
      cmp_field("is_null_marker", 32'(got.is_null_marker), 32'(want.is_null_marker));
      cmp_field("byte_offset", 32'(got.byte_offset), 32'(want.byte_offset));
      cmp_field("bit_position", 32'(got.bit_position), 32'(want.bit_position));
      cmp_field("entry_size", 32'(got.entry_size), 32'(want.entry_size));
      cmp_field("record_size", 32'(got.record_size), 32'(want.record_size));
      cmp_field("bool_byte_count", 32'(got.bool_byte_count), 32'(want.bool_byte_count));
      cmp_field("overflow", 32'(got.overflow), 32'(want.overflow));
      cmp_field("last_result", 32'(got.last_result), 32'(want.last_result));
   endtask

   // Field driver: the prediction is taken at the edge where the transfer happens.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_layout(req_payload);
         if (!req_valid || req_ready) begin
            if (field_q.size() > 0 && (no_idle || $urandom_range(99) >= 26)) begin
               req_payload <= field_q.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with random stalls and one long hold-off that backs up the block.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_payload);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request && !hold_done && rsp_valid) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(99) >= 26);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("record_field_layout_packer test failed");
         $finish;
      end
   end

   function automatic req_type make_field(logic [2:0] t, logic [15:0] sz, logic nul,
                                          logic last);
      req_type f;
      f.field_type = t;
      f.fixed_size = sz;
      f.nullable   = nul;
      f.last_field = last;
      return f;
   endfunction

   function automatic void queue_field(req_type f);
      field_q.insert(field_q.size(), f);
   endfunction

   task automatic write_reg(logic [0:0] idx, logic val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_modes(logic order, logic pad);
      write_reg(CSR_FIELD_ORDER, order);
      write_reg(CSR_PAD_MODE, pad);
      cfg_order = order;
      cfg_pad   = pad;
      @(negedge clock);
   endtask

   // Waits until every field has been taken and every result has arrived.
   task automatic drain_phase();
      while (field_q.size() != 0 || req_valid || layout_q.size() != 0) @(negedge clock);
      repeat (DRAIN_GAP) @(negedge clock);
   endtask

   // One field of every type, the largest and the zero fixed size, and the unused code.
   task automatic queue_mixed_schema();
      queue_field(make_field(FT_BOOL, 16'd0, 1'b1, 1'b0));
      queue_field(make_field(FT_BYTE, 16'd5, 1'b0, 1'b0));
      queue_field(make_field(FT_I32, 16'd0, 1'b1, 1'b0));
      queue_field(make_field(FT_I64, 16'd0, 1'b0, 1'b0));
      queue_field(make_field(FT_F64, 16'hFFFF, 1'b1, 1'b0));
      queue_field(make_field(FT_VAR32, 16'd0, 1'b0, 1'b0));
      queue_field(make_field(FT_FIXED, 16'hFFFF, 1'b0, 1'b0));
      queue_field(make_field(FT_FIXED, 16'd0, 1'b1, 1'b0));
      queue_field(make_field(FT_UNKNOWN, 16'd3, 1'b0, 1'b1));
   endtask

   // Mostly short schemas; now and then a long one that can overrun the entry store.
   task automatic queue_random_schema(inout int count);
      int          len;
      logic [2:0]  t;
      logic [15:0] sz;
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
         t  = 3'($urandom_range(7));
         sz = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(16));
         queue_field(make_field(t, sz, 1'($urandom_range(1)), i == len - 1));
      end
      count += len;
   endtask

   initial begin
      int queued;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      set_modes(1'b0, 1'b0);
      queue_mixed_schema();
      queue_field(make_field(FT_BOOL, 16'd0, 1'b0, 1'b1));
      queue_field(make_field(FT_I64, 16'd0, 1'b1, 1'b1));
      drain_phase();

      set_modes(1'b1, 1'b1);
      queue_mixed_schema();
      drain_phase();

      set_modes(1'b0, 1'b1);
      queue_field(make_field(FT_BOOL, 16'd0, 1'b1, 1'b0));
      queue_field(make_field(FT_BYTE, 16'd0, 1'b0, 1'b1));
      drain_phase();

      set_modes(1'b1, 1'b0);
      queue_field(make_field(FT_BYTE, 16'd0, 1'b0, 1'b1));
      drain_phase();

      for (int p = 0; p < 8; p++) begin
         set_modes(1'($urandom_range(1)), 1'($urandom_range(1)));
         no_idle <= (p == 2);
         if (p == 4) hold_request <= 1'b1;
         queued = 0;
         while (queued < 62) queue_random_schema(queued);
         drain_phase();
      end

      repeat (20) @(negedge clock);
      if (errors == 0) begin
         $display("record_field_layout_packer test passed");
      end else begin
         $display("record_field_layout_packer test failed");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/rflp_pkg.sv
rtl/core/rflp_ctrl.sv
rtl/core/rflp_dp.sv
rtl/core/record_field_layout_packer.sv
rtl/core/rflp_checker.sv
tb/record_field_layout_packer_tb.sv
